### rtl/tmfp_pkg.sv
// text message frame parser package: phase, event and cause codes, number helpers
// no dependencies
package tmfp_pkg;

    localparam int MARKER_MAX_BYTES = 8;
    localparam int BODY_LEN_BITS    = 16;
    localparam int CFG_ADDR_W       = 6;
    localparam int CFG_DATA_W       = 64;

    localparam logic [2:0] REG_VERSION  = 3'd0;
    localparam logic [2:0] REG_HEAD     = 3'd1;
    localparam logic [2:0] REG_HEAD_LEN = 3'd2;
    localparam logic [2:0] REG_TAIL     = 3'd3;
    localparam logic [2:0] REG_TAIL_LEN = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [32:0] NUM_SAT      = 33'h1_0000_0000;
    localparam logic [32:0] LIM16_POS    = 33'd32767;
    localparam logic [32:0] LIM16_NEG    = 33'd32768;
    localparam logic [32:0] LIM32_POS    = 33'h0_7fff_ffff;
    localparam logic [32:0] LIM32_NEG    = 33'h0_8000_0000;
    localparam logic [32:0] BODY_MAX     = 33'((64'd1 << BODY_LEN_BITS) - 64'd1);

    typedef enum logic [4:0] {
        PH_HEAD, PH_VER, PH_TYPE, PH_TID, PH_HLF, PH_OPT, PH_KEY, PH_COLON,
        PH_VQ, PH_VAL, PH_OCR, PH_OLF, PH_HASH, PH_HASHLF, PH_BCR1, PH_BLF1,
        PH_BODY, PH_BCR2, PH_BLF2, PH_TAIL, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0, EV_KEY = 3'd1, EV_VALUE = 3'd2, EV_OPTEND = 3'd3,
        EV_BODY = 3'd4, EV_OK = 3'd5, EV_ERROR = 3'd6, EV_NONE = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        CA_NONE = 3'd0, CA_MAGIC = 3'd1, CA_NUMBER = 3'd2, CA_VERSION = 3'd3,
        CA_SYNTAX = 3'd4, CA_CHECKSUM = 3'd5, CA_SIZE = 3'd6, CA_TRUNC = 3'd7
    } t_cause;

    typedef struct packed {
        logic [32:0] acc;
        logic        dig;
        logic        neg;
        logic        stop;
        logic        sgn;
    } t_num;

    function automatic t_num num_feed(input t_num n, input logic [7:0] b);
        t_num        r;
        logic [36:0] prod;
        r = n;
        prod = ({4'd0, n.acc} << 3) + ({4'd0, n.acc} << 1) + {33'd0, b[3:0]};
        if (!n.stop) begin
            if (b >= 8'h30 && b <= 8'h39) begin
                r.acc = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[32:0];
                r.dig = 1'b1;
            end else if (!(n.dig || n.sgn) && (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13))) begin
                r = n;
            end else if (!(n.dig || n.sgn) && (b == CH_PLUS || b == CH_MINUS)) begin
                r.sgn = 1'b1;
                r.neg = (b == CH_MINUS);
            end else begin
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic num_ok(input t_num n, input logic [32:0] lim_pos,
                                    input logic [32:0] lim_neg);
        return n.dig && (n.neg ? (n.acc <= lim_neg) : (n.acc <= lim_pos));
    endfunction

    function automatic logic [31:0] num_val(input t_num n);
        return n.neg ? (32'd0 - n.acc[31:0]) : n.acc[31:0];
    endfunction

    function automatic logic [3:0] marker_len(input logic [3:0] len);
        return (len > 4'(MARKER_MAX_BYTES)) ? 4'(MARKER_MAX_BYTES) : len;
    endfunction

    function automatic logic [7:0] size_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h73;
            2'd1: c = 8'h69;
            2'd2: c = 8'h7a;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

endpackage

### rtl/tmfp_if.sv
// word channels of the text message frame parser: frame input and event output
// depends on nothing
interface tmfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface tmfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] message_type;
    logic [31:0] transaction_id;
    logic [2:0]  error_cause;
    modport source (output valid, event_kind, data_byte, message_type, transaction_id,
                    error_cause, input ready);
    modport sink (input valid, event_kind, data_byte, message_type, transaction_id,
                  error_cause, output ready);
endinterface

### rtl/text_message_frame_parser.sv
// text message frame parser top level: byte parser, event register, apb registers
// depends on tmfp_pkg and tmfp_if
//
// frame bytes enter on i_in, one word per byte, frame_end set on the last byte
// events leave on o_out: header, key byte, value byte, option end, body byte,
// frame ok, or error with a cause; a byte gives at most one event
// a byte is parsed in the cycle it is accepted and its event is valid on o_out
// the next cycle; throughput is one byte per cycle while o_out is not stalled
// the event register is the only stage; i_in stays ready while o_out is empty
// or being taken, so a stalled receiver holds one event and blocks input
// after an error or frame ok the rest of the frame is dropped until frame_end;
// frame_end before ok or error gives an error with cause truncated
// reset clears the parser to wait for the head magic, empties o_out and loads
// the registers with version 1 and empty markers
// apb registers: version at 0x00, head magic 0x08, head length 0x10,
// tail magic 0x18, tail length 0x20; write only while no frame is in flight
module text_message_frame_parser
    import tmfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tmfp_in_if.sink               i_in,
    tmfp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [15:0] r_exp_ver;
    logic [63:0] r_head_magic;
    logic [3:0]  r_head_len;
    logic [63:0] r_tail_magic;
    logic [3:0]  r_tail_len;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_mpos, n_mpos;
    t_num        r_num, n_num;
    logic [15:0] r_sum, n_sum;
    logic [2:0]  r_skm, n_skm;
    logic [BODY_LEN_BITS-1:0] r_blen, n_blen;
    logic        r_sfound, n_sfound;
    logic [15:0] r_stype, n_stype;

    logic        r_out_valid;
    t_event      r_kind;
    logic [7:0]  r_data;
    logic [15:0] r_mtype;
    logic [31:0] r_tid;
    t_cause      r_cause;

    t_event      kind;
    t_cause      cause;
    logic [7:0]  data;
    logic [15:0] mtype;
    logic [31:0] tid;

    logic        in_acc;
    logic        cfg_wr;
    logic [7:0]  b;
    logic [3:0]  hlen;
    logic [3:0]  tlen;
    logic [2:0]  reg_idx;
    t_num        num_zero;
    logic [31:0] val;
    logic [BODY_LEN_BITS-1:0] blen_dec;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver    <= 16'd1;
            r_head_magic <= '0;
            r_head_len   <= '0;
            r_tail_magic <= '0;
            r_tail_len   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_VERSION:  r_exp_ver    <= pwdata[15:0];
                REG_HEAD:     r_head_magic <= pwdata;
                REG_HEAD_LEN: r_head_len   <= pwdata[3:0];
                REG_TAIL:     r_tail_magic <= pwdata;
                REG_TAIL_LEN: r_tail_len   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VERSION:  prdata = {48'd0, r_exp_ver};
            REG_HEAD:     prdata = r_head_magic;
            REG_HEAD_LEN: prdata = {60'd0, r_head_len};
            REG_TAIL:     prdata = r_tail_magic;
            REG_TAIL_LEN: prdata = {60'd0, r_tail_len};
            default:      prdata = '0;
        endcase
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign b          = i_in.frame_byte;
    assign hlen       = marker_len(r_head_len);
    assign tlen       = marker_len(r_tail_len);
    assign num_zero   = '0;
    assign val        = num_val(r_num);
    assign blen_dec   = r_blen - 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_mpos   = r_mpos;
        n_num    = r_num;
        n_sum    = r_sum;
        n_skm    = r_skm;
        n_blen   = r_blen;
        n_sfound = r_sfound;
        n_stype  = r_stype;
        kind     = EV_NONE;
        cause    = CA_NONE;
        data     = '0;
        mtype    = '0;
        tid      = '0;

        if (r_phase <= PH_OLF && !(r_phase == PH_OPT && b != CH_QUOTE)) begin
            n_sum = r_sum + {{8{b[7]}}, b};
        end

        unique case (r_phase)
            PH_HEAD: begin
                if (r_mpos < hlen) begin
                    if (b != r_head_magic[{r_mpos[2:0], 3'b000} +: 8]) begin
                        kind = EV_ERROR; cause = CA_MAGIC;
                    end else begin
                        n_mpos = r_mpos + 4'd1;
                    end
                end else if (b == CH_SPACE) begin
                    n_phase = PH_VER; n_num = num_zero;
                end else begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end
            end
            PH_VER: begin
                if (b != CH_SPACE) begin
                    n_num = num_feed(r_num, b);
                end else if (!num_ok(r_num, LIM16_POS, LIM16_NEG)) begin
                    kind = EV_ERROR; cause = CA_NUMBER;
                end else if (val[15:0] != r_exp_ver) begin
                    kind = EV_ERROR; cause = CA_VERSION;
                end else begin
                    n_phase = PH_TYPE; n_num = num_zero;
                end
            end
            PH_TYPE: begin
                if (b != CH_SPACE) begin
                    n_num = num_feed(r_num, b);
                end else if (!num_ok(r_num, LIM16_POS, LIM16_NEG)) begin
                    kind = EV_ERROR; cause = CA_NUMBER;
                end else begin
                    n_stype = val[15:0]; n_phase = PH_TID; n_num = num_zero;
                end
            end
            PH_TID: begin
                if (b != CH_CR) begin
                    n_num = num_feed(r_num, b);
                end else if (!num_ok(r_num, LIM32_POS, LIM32_NEG)) begin
                    kind = EV_ERROR; cause = CA_NUMBER;
                end else begin
                    n_num.acc = {1'b0, val}; n_phase = PH_HLF;
                end
            end
            PH_HLF: begin
                if (b != CH_LF) begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end else begin
                    kind = EV_HEADER; mtype = r_stype; tid = r_num.acc[31:0];
                    n_phase = PH_OPT;
                end
            end
            PH_OPT: begin
                if (b == CH_QUOTE) begin
                    n_phase = PH_KEY; n_skm = '0;
                end else if (b == CH_CR) begin
                    n_phase = PH_HASHLF; n_num = num_zero;
                end else begin
                    n_phase = PH_HASH; n_num = num_feed(num_zero, b);
                end
            end
            PH_KEY: begin
                if (b == CH_QUOTE) begin
                    n_phase = PH_COLON;
                end else begin
                    kind = EV_KEY; data = b;
                    if (r_skm < 3'd4 && b == size_char(r_skm[1:0])) n_skm = r_skm + 3'd1;
                    else n_skm = 3'd7;
                end
            end
            PH_COLON: begin
                if (b == CH_COLON) n_phase = PH_VQ;
                else begin kind = EV_ERROR; cause = CA_SYNTAX; end
            end
            PH_VQ: begin
                if (b == CH_QUOTE) begin n_phase = PH_VAL; n_num = num_zero; end
                else begin kind = EV_ERROR; cause = CA_SYNTAX; end
            end
            PH_VAL: begin
                if (b == CH_QUOTE) begin
                    n_phase = PH_OCR;
                end else begin
                    kind = EV_VALUE; data = b;
                    if (r_skm == 3'd4) n_num = num_feed(r_num, b);
                end
            end
            PH_OCR: begin
                if (b == CH_CR) n_phase = PH_OLF;
                else begin kind = EV_ERROR; cause = CA_SYNTAX; end
            end
            PH_OLF: begin
                if (b != CH_LF) begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end else begin
                    kind = EV_OPTEND; n_phase = PH_OPT;
                    if (r_skm == 3'd4) begin
                        if (!num_ok(r_num, LIM32_POS, LIM32_NEG)) begin
                            kind = EV_ERROR; cause = CA_NUMBER;
                        end else if ((r_num.neg && r_num.acc != '0) || r_num.acc > BODY_MAX) begin
                            kind = EV_ERROR; cause = CA_SIZE;
                        end else begin
                            n_blen = r_num.acc[BODY_LEN_BITS-1:0]; n_sfound = 1'b1;
                        end
                    end
                end
            end
            PH_HASH: begin
                if (b == CH_CR) n_phase = PH_HASHLF;
                else n_num = num_feed(r_num, b);
            end
            PH_HASHLF: begin
                if (b != CH_LF) begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end else if (!num_ok(r_num, LIM16_POS, LIM16_NEG)) begin
                    kind = EV_ERROR; cause = CA_NUMBER;
                end else if (val[15:0] != r_sum) begin
                    kind = EV_ERROR; cause = CA_CHECKSUM;
                end else begin
                    n_phase = PH_BCR1;
                end
            end
            PH_BCR1: begin
                if (b == CH_CR) n_phase = PH_BLF1;
                else begin kind = EV_ERROR; cause = CA_SYNTAX; end
            end
            PH_BLF1: begin
                if (b != CH_LF) begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end else if (!r_sfound) begin
                    kind = EV_ERROR; cause = CA_SIZE;
                end else begin
                    n_phase = (r_blen != '0) ? PH_BODY : PH_BCR2;
                end
            end
            PH_BODY: begin
                kind = EV_BODY; data = b; n_blen = blen_dec;
                if (blen_dec == '0) n_phase = PH_BCR2;
            end
            PH_BCR2: begin
                if (b == CH_CR) n_phase = PH_BLF2;
                else begin kind = EV_ERROR; cause = CA_SYNTAX; end
            end
            PH_BLF2: begin
                if (b != CH_LF) begin
                    kind = EV_ERROR; cause = CA_SYNTAX;
                end else if (tlen == '0) begin
                    kind = EV_OK; n_phase = PH_DONE;
                end else begin
                    n_phase = PH_TAIL; n_mpos = '0;
                end
            end
            PH_TAIL: begin
                if (b != r_tail_magic[{r_mpos[2:0], 3'b000} +: 8]) begin
                    kind = EV_ERROR; cause = CA_MAGIC;
                end else begin
                    n_mpos = r_mpos + 4'd1;
                    if (r_mpos + 4'd1 >= tlen) begin kind = EV_OK; n_phase = PH_DONE; end
                end
            end
            default: n_phase = PH_DONE;
        endcase

        if (kind == EV_ERROR) n_phase = PH_DONE;

        if (i_in.frame_end) begin
            if (n_phase != PH_DONE) begin
                kind = EV_ERROR; cause = CA_TRUNC;
                data = '0; mtype = '0; tid = '0;
            end
            n_phase  = PH_HEAD;
            n_mpos   = '0;
            n_num    = num_zero;
            n_sum    = '0;
            n_skm    = '0;
            n_blen   = '0;
            n_sfound = 1'b0;
            n_stype  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_mpos   <= '0;
            r_num    <= '0;
            r_sum    <= '0;
            r_skm    <= '0;
            r_blen   <= '0;
            r_sfound <= 1'b0;
            r_stype  <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_mpos   <= n_mpos;
            r_num    <= n_num;
            r_sum    <= n_sum;
            r_skm    <= n_skm;
            r_blen   <= n_blen;
            r_sfound <= n_sfound;
            r_stype  <= n_stype;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && kind != EV_NONE) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && kind != EV_NONE) begin
            r_kind  <= kind;
            r_data  <= data;
            r_mtype <= mtype;
            r_tid   <= tid;
            r_cause <= cause;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_kind     = r_kind;
    assign o_out.data_byte      = r_data;
    assign o_out.message_type   = r_mtype;
    assign o_out.transaction_id = r_tid;
    assign o_out.error_cause    = r_cause;

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_valid)
        else $error("event pending after reset");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input blocked with empty output");
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.frame_end |=> r_phase == PH_HEAD && r_sum == '0)
        else $error("frame state kept past frame end");
    a_error_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == EV_ERROR |-> r_cause != CA_NONE)
        else $error("error event without cause");
    a_cause_only_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != EV_ERROR |-> r_cause == CA_NONE)
        else $error("cause on non-error event");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the text message frame parser: directed rows, then random frames
// checked against a byte-level parser model; needs tmfp_pkg, tmfp_if and the top level
module tb_top;
    import tmfp_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] mtype;
        logic [31:0] tid;
        logic [2:0]  cause;
    } frame_event_t;

    typedef struct {
        logic [7:0]   b;
        logic         e;
        bit           typed;
        frame_event_t ev;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 1900;
    localparam logic [47:0] KEY_CHARS = "sizeaq";

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    tmfp_in_if  in_ch ();
    tmfp_out_if out_ch ();

    text_message_frame_parser DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies
    logic [15:0] cfg_ver = 16'd1;
    logic [63:0] cfg_head = '0, cfg_tail = '0;
    logic [3:0]  cfg_hlen = '0, cfg_tlen = '0;

    // parser state copies
    t_phase      ph;
    logic [3:0]  mpos;
    logic [32:0] acc;
    logic        n_dig, n_neg, n_stop, n_sgn;
    logic [15:0] csum;
    logic [2:0]  skm;
    logic [15:0] blen;
    logic        sfound;
    logic [15:0] stype;
    logic [31:0] stid;

    frame_event_t pending_events[$];
    int  fails = 0;
    int  cycles = 0;
    int  items = 0;
    bit  calm = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        fails++;
    endtask

    function automatic void expect_event(input frame_event_t ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    function automatic void queue_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    function automatic void frame_reset();
        ph = PH_HEAD; mpos = '0; acc = '0; {n_dig, n_neg, n_stop, n_sgn} = '0;
        csum = '0; skm = '0; blen = '0; sfound = 0; stype = '0; stid = '0;
    endfunction

    function automatic void digit_reset();
        acc = '0; {n_dig, n_neg, n_stop, n_sgn} = '0;
    endfunction

    function automatic void digit_feed(input logic [7:0] b);
        logic [36:0] t;
        if (n_stop) return;
        if (b >= "0" && b <= "9") begin
            t = {4'd0, acc} * 37'd10 + 37'(b - 8'h30);
            acc = (t > 37'h1_0000_0000) ? 33'h1_0000_0000 : t[32:0];
            n_dig = 1;
        end else if (!(n_dig || n_sgn) && (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13))) begin
        end else if (!(n_dig || n_sgn) && (b == CH_PLUS || b == CH_MINUS)) begin
            n_sgn = 1;
            n_neg = (b == CH_MINUS);
        end else begin
            n_stop = 1;
        end
    endfunction

    function automatic bit digit_result(input logic [32:0] lpos, input logic [32:0] lneg,
                                        output logic [31:0] val);
        val = '0;
        if (!n_dig) return 0;
        if (n_neg) begin
            if (acc > lneg) return 0;
            val = 32'd0 - acc[31:0];
        end else begin
            if (acc > lpos) return 0;
            val = acc[31:0];
        end
        return 1;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [63:0] m, input logic [3:0] p);
        return m[p[2:0]*8 +: 8];
    endfunction

    // one frame byte through the parser model; returns 1 when an event comes out
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output frame_event_t ev);
        t_event      k;
        t_cause      c;
        logic [31:0] v;
        logic [3:0]  hl, tl;
        k = EV_NONE; c = CA_NONE; ev = '0;
        hl = (cfg_hlen > 4'd8) ? 4'd8 : cfg_hlen;
        tl = (cfg_tlen > 4'd8) ? 4'd8 : cfg_tlen;
        if (ph <= PH_OLF && !(ph == PH_OPT && b != CH_QUOTE))
            csum = csum + {{8{b[7]}}, b};
        case (ph)
            PH_HEAD: begin
                if (mpos < hl) begin
                    if (b != magic_byte(cfg_head, mpos)) begin k = EV_ERROR; c = CA_MAGIC; end
                    else mpos++;
                end else if (b == CH_SPACE) begin
                    ph = PH_VER; digit_reset();
                end else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_VER: begin
                if (b != CH_SPACE) digit_feed(b);
                else if (!digit_result(LIM16_POS, LIM16_NEG, v)) begin
                    k = EV_ERROR; c = CA_NUMBER;
                end else if (v[15:0] != cfg_ver) begin k = EV_ERROR; c = CA_VERSION; end
                else begin ph = PH_TYPE; digit_reset(); end
            end
            PH_TYPE: begin
                if (b != CH_SPACE) digit_feed(b);
                else if (!digit_result(LIM16_POS, LIM16_NEG, v)) begin
                    k = EV_ERROR; c = CA_NUMBER;
                end else begin stype = v[15:0]; ph = PH_TID; digit_reset(); end
            end
            PH_TID: begin
                if (b != CH_CR) digit_feed(b);
                else if (!digit_result(LIM32_POS, LIM32_NEG, v)) begin
                    k = EV_ERROR; c = CA_NUMBER;
                end else begin stid = v; ph = PH_HLF; end
            end
            PH_HLF: begin
                if (b != CH_LF) begin k = EV_ERROR; c = CA_SYNTAX; end
                else begin
                    k = EV_HEADER; ev.mtype = stype; ev.tid = stid; ph = PH_OPT;
                end
            end
            PH_OPT: begin
                if (b == CH_QUOTE) begin ph = PH_KEY; skm = '0; end
                else begin
                    ph = PH_HASH; digit_reset();
                    if (b == CH_CR) ph = PH_HASHLF;
                    else digit_feed(b);
                end
            end
            PH_KEY: begin
                if (b == CH_QUOTE) ph = PH_COLON;
                else begin
                    k = EV_KEY; ev.data = b;
                    if (skm < 3'd4 && b == 8'("size" >> (8 * (3 - skm)))) skm++;
                    else skm = 3'd7;
                end
            end
            PH_COLON: begin
                if (b == CH_COLON) ph = PH_VQ;
                else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_VQ: begin
                if (b == CH_QUOTE) begin ph = PH_VAL; digit_reset(); end
                else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_VAL: begin
                if (b == CH_QUOTE) ph = PH_OCR;
                else begin
                    k = EV_VALUE; ev.data = b;
                    if (skm == 3'd4) digit_feed(b);
                end
            end
            PH_OCR: begin
                if (b == CH_CR) ph = PH_OLF;
                else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_OLF: begin
                if (b != CH_LF) begin k = EV_ERROR; c = CA_SYNTAX; end
                else begin
                    k = EV_OPTEND; ph = PH_OPT;
                    if (skm == 3'd4) begin
                        if (!digit_result(LIM32_POS, LIM32_NEG, v)) begin
                            k = EV_ERROR; c = CA_NUMBER;
                        end else if ((n_neg && acc != 0) || (!n_neg && acc > 33'd65535)) begin
                            k = EV_ERROR; c = CA_SIZE;
                        end else begin blen = v[15:0]; sfound = 1; end
                    end
                end
            end
            PH_HASH: begin
                if (b == CH_CR) ph = PH_HASHLF;
                else digit_feed(b);
            end
            PH_HASHLF: begin
                if (b != CH_LF) begin k = EV_ERROR; c = CA_SYNTAX; end
                else if (!digit_result(LIM16_POS, LIM16_NEG, v)) begin
                    k = EV_ERROR; c = CA_NUMBER;
                end else if (v[15:0] != csum) begin k = EV_ERROR; c = CA_CHECKSUM; end
                else ph = PH_BCR1;
            end
            PH_BCR1: begin
                if (b == CH_CR) ph = PH_BLF1;
                else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_BLF1: begin
                if (b != CH_LF) begin k = EV_ERROR; c = CA_SYNTAX; end
                else if (!sfound) begin k = EV_ERROR; c = CA_SIZE; end
                else ph = (blen != 0) ? PH_BODY : PH_BCR2;
            end
            PH_BODY: begin
                k = EV_BODY; ev.data = b;
                blen = blen - 16'd1;
                if (blen == 0) ph = PH_BCR2;
            end
            PH_BCR2: begin
                if (b == CH_CR) ph = PH_BLF2;
                else begin k = EV_ERROR; c = CA_SYNTAX; end
            end
            PH_BLF2: begin
                if (b != CH_LF) begin k = EV_ERROR; c = CA_SYNTAX; end
                else if (tl == 0) begin k = EV_OK; ph = PH_DONE; end
                else begin ph = PH_TAIL; mpos = '0; end
            end
            PH_TAIL: begin
                if (b != magic_byte(cfg_tail, mpos)) begin k = EV_ERROR; c = CA_MAGIC; end
                else begin
                    mpos++;
                    if (mpos >= tl) begin k = EV_OK; ph = PH_DONE; end
                end
            end
            default: ph = PH_DONE;
        endcase
        if (k == EV_ERROR) ph = PH_DONE;
        if (last) begin
            if (ph != PH_DONE) begin
                k = EV_ERROR; c = CA_TRUNC; ev = '0;
            end
            frame_reset();
        end
        if (k != EV_ERROR && k != EV_HEADER) begin ev.mtype = '0; ev.tid = '0; end
        ev.kind = k;
        ev.cause = c;
        return k != EV_NONE;
    endfunction

    // output side: random stalls and the comparison
    int stall_left = 0;
    always @(posedge i_clk) begin
        frame_event_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_events.size() == 0) report("event with nothing expected");
            else begin
                want = pending_events.pop_front();
                if (out_ch.event_kind !== want.kind)
                    report($sformatf("kind %0d want %0d", out_ch.event_kind, want.kind));
                if (out_ch.data_byte !== want.data)
                    report($sformatf("data %h want %h", out_ch.data_byte, want.data));
                if (out_ch.message_type !== want.mtype)
                    report($sformatf("type %h want %h", out_ch.message_type, want.mtype));
                if (out_ch.transaction_id !== want.tid)
                    report($sformatf("tid %h want %h", out_ch.transaction_id, want.tid));
                if (out_ch.error_cause !== want.cause)
                    report($sformatf("cause %0d want %0d", out_ch.error_cause, want.cause));
            end
        end
        if (calm) out_ch.ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else out_ch.ready <= 1'b1;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 3'b000}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_VERSION:  cfg_ver = val[15:0];
            REG_HEAD:     cfg_head = val;
            REG_HEAD_LEN: cfg_hlen = val[3:0];
            REG_TAIL:     cfg_tail = val;
            REG_TAIL_LEN: cfg_tlen = val[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] ver, input logic [63:0] hm,
                                 input logic [3:0] hl, input logic [63:0] tm,
                                 input logic [3:0] tl);
        drain();
        reg_write(REG_VERSION, {48'd0, ver});
        reg_write(REG_HEAD, hm);
        reg_write(REG_HEAD_LEN, {60'd0, hl});
        reg_write(REG_TAIL, tm);
        reg_write(REG_TAIL_LEN, {60'd0, tl});
        @(posedge i_clk);
    endtask

    // one word on the input channel; returns after acceptance at a clock edge
    task automatic send_word(input logic [7:0] b, input logic e, input bit typed,
                             input frame_event_t typed_ev);
        frame_event_t ev;
        if (!calm && $urandom_range(0, 11) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.frame_byte <= b;
        in_ch.frame_end <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (parse_byte(b, e, ev) && !typed) expect_event(ev);
        if (typed) expect_event(typed_ev);
        items++;
    endtask

    task automatic send_frame(ref logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++) send_word(q[i], i == q.size() - 1, 0, '0);
    endtask

    function automatic void put_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(q, s[i]);
    endfunction

    function automatic void put_num(ref logic [7:0] q[$], input longint v, input bit bare);
        int deco;
        deco = bare ? 0 : $urandom_range(0, 7);
        if (deco == 1 && v >= 0) queue_byte(q, CH_PLUS);
        if (deco == 2) queue_byte(q, 8'h09);
        put_text(q, $sformatf("%0d", v));
        if (deco == 3) queue_byte(q, "q");
    endfunction

    function automatic void put_magic(ref logic [7:0] q[$], input logic [63:0] m,
                                      input logic [3:0] len);
        for (int i = 0; i < ((len > 8) ? 8 : len); i++) queue_byte(q, m[i*8 +: 8]);
    endfunction

    // builds one frame, mostly well formed, with a random fault now and then
    function automatic void build_frame(ref logic [7:0] q[$]);
        int          fault, nopt, spos, blen_w;
        logic [15:0] sum;
        logic [7:0]  c;
        q.delete();
        fault = $urandom_range(0, 24);
        if (fault == 10) begin
            repeat ($urandom_range(1, 10)) queue_byte(q, 8'($urandom_range(0, 255)));
            return;
        end
        blen_w = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
        put_magic(q, cfg_head, cfg_hlen);
        queue_byte(q, CH_SPACE);
        if (fault == 9) ;
        else if (fault == 0) put_num(q, longint'(signed'(16'(cfg_ver + 16'd1))), 0);
        else put_num(q, longint'(signed'(cfg_ver)), 0);
        queue_byte(q, CH_SPACE);
        if (fault == 1) put_num(q, $urandom_range(0, 1) ? 40000 : -32769, 1);
        else put_num(q, longint'(signed'(16'($urandom))), 0);
        queue_byte(q, CH_SPACE);
        if (fault == 2) put_num(q, $urandom_range(0, 1) ? 64'sd3000000000 : -64'sd2147483649, 1);
        else put_num(q, longint'(signed'(32'($urandom))), 0);
        put_text(q, "\r\n");
        nopt = $urandom_range(0, 3);
        spos = $urandom_range(0, nopt);
        for (int o = 0; o <= nopt; o++) begin
            if (o == spos && fault != 5) begin
                put_text(q, "\"size\":\"");
                if (fault == 3) put_num(q, -longint'($urandom_range(1, 9)), 1);
                else if (fault == 4) put_num(q, $urandom_range(65536, 99999), 1);
                else put_num(q, blen_w, 0);
                put_text(q, "\"\r\n");
            end else if (o != spos) begin
                queue_byte(q, CH_QUOTE);
                repeat ($urandom_range(1, 4)) begin
                    c = KEY_CHARS[8 * $urandom_range(0, 5) +: 8];
                    queue_byte(q, c);
                end
                put_text(q, "\":\"");
                repeat ($urandom_range(0, 5)) begin
                    c = 8'($urandom_range(0, 255));
                    queue_byte(q, c == CH_QUOTE ? 8'h23 : c);
                end
                put_text(q, "\"\r\n");
            end
        end
        sum = '0;
        foreach (q[i]) sum = sum + {{8{q[i][7]}}, q[i]};
        if (fault == 6) sum = sum + 16'd1;
        put_num(q, longint'(signed'(sum)), 0);
        put_text(q, "\r\n\r\n");
        repeat (blen_w) queue_byte(q, 8'($urandom_range(0, 255)));
        put_text(q, "\r\n");
        put_magic(q, cfg_tail, cfg_tlen);
        repeat ($urandom_range(0, 2)) queue_byte(q, 8'($urandom_range(0, 255)));
        if (fault == 7) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        if (fault == 8) while (q.size() > 1 && $urandom_range(0, 3) != 0) void'(q.pop_back());
    endfunction

    function automatic frame_event_t err_event(input t_cause c);
        frame_event_t e;
        e = '0; e.kind = EV_ERROR; e.cause = c;
        return e;
    endfunction

    initial begin
        stim_row_t    rows[$];
        stim_row_t    r;
        frame_event_t hdr;
        logic [7:0]   fq[$];
        string        hs;
        int           nframes;
        in_ch.valid = 1'b0; in_ch.frame_byte = '0; in_ch.frame_end = 1'b0;
        out_ch.ready = 1'b0;
        frame_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows after reset: version 1, no markers
        rows.insert(rows.size(), '{"x", 1'b0, 1, err_event(CA_SYNTAX)});
        rows.insert(rows.size(), '{"y", 1'b1, 0, '0});
        rows.insert(rows.size(), '{CH_SPACE, 1'b1, 1, err_event(CA_TRUNC)});
        hs = " 1 -32768 2147483647\r";
        for (int i = 0; i < hs.len(); i++) rows.insert(rows.size(), '{hs[i], 1'b0, 0, '0});
        hdr = '0; hdr.kind = EV_HEADER; hdr.mtype = 16'h8000; hdr.tid = 32'h7fff_ffff;
        rows.insert(rows.size(), '{CH_LF, 1'b0, 1, hdr});
        rows.insert(rows.size(), '{8'hff, 1'b1, 1, err_event(CA_TRUNC)});
        foreach (rows[i]) begin
            r = rows[i];
            send_word(r.b, r.e, r.typed, r.ev);
        end

        nframes = 0;
        while (items < ITEM_GOAL) begin
            if (nframes % 10 == 0) begin
                in_ch.valid <= 1'b0;
                case ((nframes / 10) % 5)
                    0: load_settings(16'h8000, {$urandom, $urandom}, 4'd8,
                                     {$urandom, $urandom}, 4'd8);
                    1: load_settings(16'h7fff, 64'hffff_ffff_ffff_ffff, 4'd15,
                                     64'h0, 4'd9);
                    2: load_settings(16'($urandom), {$urandom, $urandom},
                                     4'($urandom_range(1, 7)), {$urandom, $urandom},
                                     4'($urandom_range(1, 7)));
                    3: load_settings(16'd1, 64'h0, 4'd0, 64'h0, 4'd0);
                    default: load_settings(16'($urandom), {$urandom, $urandom}, 4'd3,
                                           64'h0, 4'd0);
                endcase
            end
            if (items > ITEM_GOAL - 300) calm = 1;
            build_frame(fq);
            send_frame(fq);
            nframes++;
        end
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fails == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
